@@ rtl/wsdf_pkg.sv @@
`default_nettype none

package wsdf_pkg;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [1:0] ACT_TEXT   = 2'd0;
  localparam logic [1:0] ACT_BINARY = 2'd1;
  localparam logic [1:0] ACT_PONG   = 2'd2;
  localparam logic [1:0] ACT_CLOSE  = 2'd3;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [1:0] action;
    logic       frame_end;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/wsdf_in_stage.sv @@
`default_nettype none

module wsdf_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_cmd,
  input  wire  [7:0]          in_data_byte,
  input  wire                 advance,
  output logic                beat_vld,
  output wsdf_pkg::beat_t     beat
);

  logic            vld_r;
  logic            vld_nxt;
  wsdf_pkg::beat_t beat_r;
  logic            load;

  assign in_stall = vld_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      beat_r.cmd       <= in_cmd;
      beat_r.data_byte <= in_data_byte;
    end
  end

  assign beat_vld = vld_r;
  assign beat     = beat_r;

endmodule

`default_nettype wire

@@ rtl/wsdf_parser.sv @@
`default_nettype none

module wsdf_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  wsdf_pkg::beat_t     beat,
  output logic                res_vld,
  output wsdf_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  logic                   active_r, active_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             ext_cnt_r, ext_cnt_nxt;
  logic                   mask_r, mask_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic [LENGTH_BITS-1:0] bl_r, bl_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             pos_r, pos_nxt;

  logic       hdr_done;
  logic       start_pl;
  logic       do_close;
  logic [7:0] b;
  logic [6:0] len7;
  logic [7:0] key_byte;
  logic [7:0] unmasked;
  logic       last;

  function automatic logic data_act(input logic [3:0] op, output logic [1:0] act);
    data_act = 1'b1;
    act      = wsdf_pkg::ACT_TEXT;
    case (op)
      wsdf_pkg::OP_TEXT:   act = wsdf_pkg::ACT_TEXT;
      wsdf_pkg::OP_BINARY: act = wsdf_pkg::ACT_BINARY;
      wsdf_pkg::OP_PING:   act = wsdf_pkg::ACT_PONG;
      default:             data_act = 1'b0;
    endcase
  endfunction

  assign b    = beat.data_byte;
  assign len7 = b[6:0];

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign unmasked = mask_r ? (b ^ key_byte) : b;

  always_comb begin
    logic [1:0] act;
    active_nxt  = active_r;
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    mask_nxt    = mask_r;
    opcode_nxt  = opcode_r;
    bl_nxt      = bl_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    hdr_done    = 1'b0;
    start_pl    = 1'b0;
    do_close    = 1'b0;
    last        = 1'b0;
    act         = wsdf_pkg::ACT_TEXT;
    res_vld     = 1'b0;
    res         = '0;

    if (step && active_r) begin
      if (beat.cmd) begin
        do_close = 1'b1;
      end else begin
        case (phase_r)
          PH_HDR1: begin
            mask_nxt = b[7];
            if (len7 < wsdf_pkg::LEN7_EXT16) begin
              bl_nxt   = {{(LENGTH_BITS-7){1'b0}}, len7};
              hdr_done = 1'b1;
            end else begin
              bl_nxt      = '0;
              ext_cnt_nxt = (len7 == wsdf_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
              phase_nxt   = PH_EXT;
            end
          end
          PH_EXT: begin
            if (|bl_r[LENGTH_BITS-1:LENGTH_BITS-8]) begin
              bl_nxt = '1;
            end else begin
              bl_nxt = {bl_r[LENGTH_BITS-9:0], b};
            end
            if (ext_cnt_r == 3'd0) begin
              hdr_done = 1'b1;
            end else begin
              ext_cnt_nxt = ext_cnt_r - 3'd1;
            end
          end
          PH_MASK: begin
            key_nxt = {key_r[23:0], b};
            pos_nxt = pos_r + 2'd1;
            if (pos_r == 2'd3) begin
              start_pl = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            pos_nxt = pos_r + 2'd1;
            bl_nxt  = bl_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            last    = (bl_nxt == '0);
            if (last) begin
              phase_nxt = PH_HDR0;
            end
            if (opcode_r == wsdf_pkg::OP_CLOSE) begin
              do_close = last;
            end else if (data_act(opcode_r, act)) begin
              res_vld          = 1'b1;
              res.payload_byte = unmasked;
              res.has_byte     = 1'b1;
              res.action       = act;
              res.frame_end    = last;
            end
          end
          default: begin
            opcode_nxt = b[3:0];
            phase_nxt  = PH_HDR1;
          end
        endcase

        if (hdr_done) begin
          pos_nxt = 2'd0;
          if (mask_nxt) begin
            key_nxt   = '0;
            phase_nxt = PH_MASK;
          end else begin
            start_pl = 1'b1;
          end
        end

        if (start_pl) begin
          pos_nxt = 2'd0;
          if (bl_nxt == '0) begin
            phase_nxt = PH_HDR0;
            if (opcode_r == wsdf_pkg::OP_CLOSE) begin
              do_close = 1'b1;
            end else if (data_act(opcode_r, act)) begin
              res_vld       = 1'b1;
              res.action    = act;
              res.frame_end = 1'b1;
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end

      if (do_close) begin
        active_nxt    = 1'b0;
        phase_nxt     = PH_HDR0;
        res_vld       = 1'b1;
        res           = '0;
        res.action    = wsdf_pkg::ACT_CLOSE;
        res.frame_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b1;
      phase_r   <= PH_HDR0;
      ext_cnt_r <= 3'd0;
      mask_r    <= 1'b0;
      opcode_r  <= 4'd0;
      bl_r      <= '0;
      key_r     <= '0;
      pos_r     <= 2'd0;
    end else begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      mask_r    <= mask_nxt;
      opcode_r  <= opcode_nxt;
      bl_r      <= bl_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
    end
  end

  a_no_result_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> !res_vld)
    else $error("result emitted after session close");

  a_close_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.action == wsdf_pkg::ACT_CLOSE |=> !active_r)
    else $error("close result did not end session");

  a_byte_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.has_byte |-> phase_r == PH_PAYLOAD)
    else $error("payload byte outside payload phase");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> bl_r != '0)
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_top.sv @@
// An accepted beat is held in the input register, and its result in the result register on out_*.
// Throughput: one beat per cycle while out_stall is low; the input register and the result register
// each take a new beat whenever the next stage moves.
// Reset: synchronous active-low rst_n empties both registers, opens the session
// and returns the parser to awaiting the first header byte.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_cmd,
  input  wire  [7:0] in_data_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic [1:0] out_action,
  output logic       out_frame_end
);

  logic              beat_vld;
  wsdf_pkg::beat_t   beat;
  logic              advance;
  logic              res_vld;
  wsdf_pkg::result_t res;
  logic              out_vld_r, out_vld_nxt;
  wsdf_pkg::result_t out_r;

  assign advance = beat_vld && (!out_vld_r || !out_stall);

  wsdf_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .beat_vld     (beat_vld),
    .beat         (beat)
  );

  wsdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .beat    (beat),
    .res_vld (res_vld),
    .res     (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_has_byte     = out_r.has_byte;
  assign out_action       = out_r.action;
  assign out_frame_end    = out_r.frame_end;

endmodule

`default_nettype wire

@@ tb/sv/deframer_check.sv @@
`timescale 1ns / 1ps

module deframer_check #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_payload_byte,
  input  logic       out_has_byte,
  input  logic [1:0] out_action,
  input  logic       out_frame_end,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT_LEN,
    PH_KEY,
    PH_PAYLOAD
  } parse_phase_t;

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  logic          active;
  parse_phase_t  phase;
  logic [2:0]    ext_due;
  logic          masked;
  logic [3:0]    opcode;
  logic [63:0]   left;
  logic [31:0]   key;
  logic [1:0]    key_pos;

  wsdf_pkg::result_t due_results[$];
  wsdf_pkg::result_t predicted;
  wsdf_pkg::result_t oldest;

  function automatic bit opcode_action(output logic [1:0] act);
    act = wsdf_pkg::ACT_TEXT;
    if (opcode == wsdf_pkg::OP_TEXT) return 1'b1;
    if (opcode == wsdf_pkg::OP_BINARY) begin
      act = wsdf_pkg::ACT_BINARY;
      return 1'b1;
    end
    if (opcode == wsdf_pkg::OP_PING) begin
      act = wsdf_pkg::ACT_PONG;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit shut_session(output wsdf_pkg::result_t r);
    active = 1'b0;
    phase = PH_HDR0;
    r = '0;
    r.action = wsdf_pkg::ACT_CLOSE;
    r.frame_end = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit begin_payload(output wsdf_pkg::result_t r);
    logic [1:0] act;
    r = '0;
    key_pos = '0;
    if (left != '0) begin
      phase = PH_PAYLOAD;
      return 1'b0;
    end
    phase = PH_HDR0;
    if (opcode == wsdf_pkg::OP_CLOSE) return shut_session(r);
    if (!opcode_action(act)) return 1'b0;
    r.action = act;
    r.frame_end = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit finish_header(output wsdf_pkg::result_t r);
    r = '0;
    key_pos = '0;
    if (masked) begin
      key = '0;
      phase = PH_KEY;
      return 1'b0;
    end
    return begin_payload(r);
  endfunction

  function automatic bit parse_stream_byte(input logic eos, input logic [7:0] b,
                                           output wsdf_pkg::result_t r);
    logic [6:0] len7;
    logic [7:0] plain;
    logic [1:0] act;
    logic       last;
    r = '0;
    if (!active) return 1'b0;
    if (eos) return shut_session(r);
    case (phase)
      PH_HDR1: begin
        masked = b[7];
        len7 = b[6:0];
        left = '0;
        if (len7 < wsdf_pkg::LEN7_EXT16) begin
          left = 64'(len7);
          return finish_header(r);
        end
        ext_due = (len7 == wsdf_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
        phase = PH_EXT_LEN;
        return 1'b0;
      end
      PH_EXT_LEN: begin
        if (left > (LEN_MAX >> 8)) left = LEN_MAX;
        else left = (left << 8) | 64'(b);
        if (ext_due == '0) return finish_header(r);
        ext_due = ext_due - 3'd1;
        return 1'b0;
      end
      PH_KEY: begin
        key = {key[23:0], b};
        key_pos = key_pos + 2'd1;
        if (key_pos == '0) return begin_payload(r);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        plain = b ^ (masked ? key[8 * (3 - int'(key_pos)) +: 8] : 8'h00);
        key_pos = key_pos + 2'd1;
        left = (left - 64'd1) & LEN_MAX;
        last = (left == '0);
        if (last) phase = PH_HDR0;
        if (opcode == wsdf_pkg::OP_CLOSE) return last ? shut_session(r) : 1'b0;
        if (!opcode_action(act)) return 1'b0;
        r.payload_byte = plain;
        r.has_byte = 1'b1;
        r.action = act;
        r.frame_end = last;
        return 1'b1;
      end
      default: begin
        opcode = b[3:0];
        phase = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active = 1'b1;
      phase = PH_HDR0;
      ext_due = '0;
      masked = 1'b0;
      opcode = '0;
      left = '0;
      key = '0;
      key_pos = '0;
      due_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: payload_byte 0x%0h has_byte %0b action %0d frame_end %0b",
                 out_payload_byte, out_has_byte, out_action, out_frame_end);
          fail_count++;
        end else begin
          oldest = due_results.pop_front();
          compare_field("payload_byte", oldest.payload_byte, out_payload_byte);
          compare_field("has_byte", oldest.has_byte, out_has_byte);
          compare_field("action", oldest.action, out_action);
          compare_field("frame_end", oldest.frame_end, out_frame_end);
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_stream_byte(in_cmd, in_data_byte, predicted))
          due_results.push_back(predicted);
      end
      pending <= due_results.size();
    end
  end

endmodule

@@ tb/sv/websocket_frame_deframer_top_test.sv @@
`timescale 1ns / 1ps

module websocket_frame_deframer_top_test;

  localparam int          LENGTH_BITS = 64;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RANDOM_BEATS = 450;
  localparam logic [6:0]  LEN7_EXT64 = 7'd127;
  localparam logic [3:0]  OP_CONT = 4'h0;
  localparam logic [3:0]  OP_PONG = 4'hA;

  typedef enum int {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_form_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_cmd;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic [1:0] out_action;
  logic       out_frame_end;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int beats_sent = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  websocket_frame_deframer_top #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload_byte(out_payload_byte),
    .out_has_byte(out_has_byte),
    .out_action(out_action),
    .out_frame_end(out_frame_end)
  );

  deframer_check #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload_byte(out_payload_byte),
    .out_has_byte(out_has_byte),
    .out_action(out_action),
    .out_frame_end(out_frame_end),
    .fail_count(fail_count),
    .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** websocket_frame_deframer_top: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input logic eos, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= eos;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic masked, input len_form_t form,
                            input logic [63:0] len, input int body);
    send_beat(1'b0, hdr0);
    case (form)
      LEN_SHORT: send_beat(1'b0, {masked, len[6:0]});
      LEN_16: begin
        send_beat(1'b0, {masked, wsdf_pkg::LEN7_EXT16});
        send_beat(1'b0, len[15:8]);
        send_beat(1'b0, len[7:0]);
      end
      default: begin
        send_beat(1'b0, {masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_beat(1'b0, len[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_beat(1'b0, 8'($urandom_range(0, 255)));
    repeat (body) send_beat(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // random frame: mostly well-formed data/control frames, a little header noise
  task automatic send_random_frame();
    int         pick;
    logic [3:0] op;
    logic [3:0] flags;
    logic [7:0] hdr0;
    logic       masked;
    len_form_t  form;
    int         len;
    pick = $urandom_range(0, 19);
    flags = 4'($urandom_range(0, 15));
    masked = ($urandom_range(0, 4) != 0);
    if (pick <= 6) op = wsdf_pkg::OP_TEXT;
    else if (pick <= 11) op = wsdf_pkg::OP_BINARY;
    else if (pick <= 14) op = wsdf_pkg::OP_PING;
    else if (pick <= 16) op = OP_PONG;
    else if (pick == 17) op = OP_CONT;
    else begin
      op = 4'($urandom_range(3, 12));
      if (op > 4'd7) op = op + 4'd3;
    end
    hdr0 = {flags, op};
    if (pick == 19) begin
      hdr0 = 8'($urandom_range(0, 255));
      if (hdr0[3:0] == wsdf_pkg::OP_CLOSE) hdr0[0] = 1'b1;
    end
    case ($urandom_range(0, 9))
      7, 8: begin
        form = LEN_16;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 40);
      end
      9: begin
        form = LEN_64;
        len = $urandom_range(0, 30);
      end
      default: begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end
    endcase
    send_frame(hdr0, masked, form, 64'(len), len);
  endtask

  initial begin
    int         tail;
    logic [3:0] op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_data_byte = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame({4'h8, wsdf_pkg::OP_TEXT}, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame({4'h8, wsdf_pkg::OP_BINARY}, 1'b1, LEN_SHORT, 64'd0, 0);
    send_frame({4'h8, wsdf_pkg::OP_PING}, 1'b1, LEN_SHORT, 64'd2, 2);
    send_frame({4'h8, OP_PONG}, 1'b0, LEN_SHORT, 64'd1, 1);
    send_frame({4'hF, wsdf_pkg::OP_BINARY}, 1'b0, LEN_16, 64'd3, 3);

    while (beats_sent < RANDOM_BEATS) send_random_frame();

    // end the session: a close frame, or end of stream inside a huge frame
    tail = $urandom_range(0, 1);
    if (tail == 0) begin
      send_frame({4'($urandom_range(0, 15)), wsdf_pkg::OP_CLOSE},
                 1'($urandom_range(0, 1)), LEN_SHORT,
                 64'($urandom_range(0, 6)), 0);
    end else begin
      op = ($urandom_range(0, 1) == 0) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_PING;
      send_frame({4'h0, op}, 1'b1, LEN_64, {64{1'b1}}, $urandom_range(0, 8));
      send_beat(1'b1, 8'($urandom_range(0, 255)));
    end
    repeat (6) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** websocket_frame_deframer_top: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule

@@ files.f @@
rtl/wsdf_pkg.sv
rtl/wsdf_in_stage.sv
rtl/wsdf_parser.sv
rtl/websocket_frame_deframer_top.sv
tb/sv/deframer_check.sv
tb/sv/websocket_frame_deframer_top_test.sv
